FILE: design/elcsr_pkg.sv
// ----------------------------------------------------------------------------
// elcsr_pkg
// Shared widths, defaults and codes for the edge list to CSR builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package elcsr_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    localparam int OP_W    = 3;
    localparam int NODE_W  = 10;
    localparam int INDEX_W = 13;
    localparam int VALUE_W = 13;
    localparam int STAT_W  = 3;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_BUILD   = 3'd1;
    localparam logic [OP_W-1:0] OP_OUT_OFF = 3'd2;
    localparam logic [OP_W-1:0] OP_OUT_NB  = 3'd3;
    localparam logic [OP_W-1:0] OP_IN_OFF  = 3'd4;
    localparam logic [OP_W-1:0] OP_IN_NB   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_SELF     = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_INDEX    = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTBUILT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 1'b1;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;

endpackage

`default_nettype wire

FILE: design/edge_list_to_csr_builder_top.sv
// ----------------------------------------------------------------------------
// edge_list_to_csr_builder_top
// Loads an edge list and builds a forward CSR table from it, and a reverse one when enabled.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low; its single
// result appears on value/status with done high for one cycle. The receiver
// cannot stall; every result is taken as it appears.
// Registers are written through write_enable/write_index/write_data by the user
// only while idle (the block does not enforce it); writes take effect at once.
// Steps from transfer to done, one item at a time (busy high meanwhile):
//   add edge              counter read-modify-write
//   build, already built  answered at once
//   build                 prefix sum (a read and a write state per node), then
//                         the scatter (read, address and write states per
//                         stored edge), then a pass clears every degree
//                         counter
//   offset read           offset fetch; neighbour read: total, check, fetch
//   unknown opcode        answered at once, value and status zero
// After reset a clearing pass zeroes every degree counter; busy stays high
// until it ends. No new item is taken before the last is through: the next
// item is taken once busy falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edge_list_to_csr_builder_top #(
    parameter int MAX_NODES = elcsr_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = elcsr_pkg::DEF_MAX_EDGES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [elcsr_pkg::OP_W-1:0]    opcode,
    input  wire logic [elcsr_pkg::NODE_W-1:0]  source_node,
    input  wire logic [elcsr_pkg::NODE_W-1:0]  target_node,
    input  wire logic [elcsr_pkg::INDEX_W-1:0] read_index,
    output logic                               done,
    output logic [elcsr_pkg::VALUE_W-1:0]      value,
    output logic [elcsr_pkg::STAT_W-1:0]       status,
    input  wire logic                          write_enable,
    input  wire logic [elcsr_pkg::CFG_IDX_W-1:0] write_index,
    input  wire logic [elcsr_pkg::CFG_W-1:0]   write_data
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int OAW = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int VW  = elcsr_pkg::VALUE_W;
    localparam int SW  = elcsr_pkg::STAT_W;
    localparam int FW  = elcsr_pkg::NODE_W;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_SC_RD,
        S_SC_ADR,
        S_SC_WR,
        S_CLR,
        S_RD_OFF,
        S_RD_TOT,
        S_RD_CHK,
        S_RD_NB
    } state_t;

    state_t state_reg, state_next;

    logic [elcsr_pkg::CFG_W-1:0]   node_count_reg;
    logic                          reverse_enable_reg;
    logic                          ready_reg, ready_next;
    logic                          rev_ready_reg, rev_ready_next;
    logic [ECW-1:0]                count_reg, count_next;
    logic [NCW-1:0]                i_reg, i_next;
    logic [ECW-1:0]                e_reg, e_next;
    logic [ECW-1:0]                oacc_reg, oacc_next;
    logic [ECW-1:0]                iacc_reg, iacc_next;
    logic [elcsr_pkg::OP_W-1:0]    op_reg, op_next;
    logic [FW-1:0]                 s_reg, s_next;
    logic [FW-1:0]                 t_reg, t_next;
    logic [elcsr_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic                          done_reg, done_next;
    logic [VW-1:0]                 value_reg, value_next;
    logic [SW-1:0]                 status_reg, status_next;

    logic [NCW-1:0] n_live;
    logic           accept;
    logic           is_in;

    // memory ports
    logic           st_we;
    logic [EAW-1:0] st_waddr, st_raddr;
    logic [FW-1:0]  src_q, tgt_q;
    logic           ocnt_we, icnt_we;
    logic [NW-1:0]  ocnt_waddr, icnt_waddr, ocnt_raddr, icnt_raddr;
    logic [ECW-1:0] ocnt_wdata, icnt_wdata, ocnt_q, icnt_q;
    logic           ooff_we, ioff_we;
    logic [OAW-1:0] off_waddr, ooff_raddr, ioff_raddr;
    logic [ECW-1:0] ooff_wdata, ioff_wdata, ooff_q, ioff_q;
    logic           onb_we, inb_we;
    logic [EAW-1:0] onb_waddr, inb_waddr, nb_raddr;
    logic [FW-1:0]  onb_wdata, inb_wdata, onb_q, inb_q;
    logic [ECW-1:0] off_sel_q;
    logic [FW-1:0]  nb_sel_q;
    logic           o_hit, i_hit;

    assign n_live = (32'(node_count_reg) > 32'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                            : NCW'(node_count_reg);
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign value  = value_reg;
    assign status = status_reg;
    assign is_in  = (op_reg == elcsr_pkg::OP_IN_OFF) || (op_reg == elcsr_pkg::OP_IN_NB);
    assign off_sel_q = is_in ? ioff_q : ooff_q;
    assign nb_sel_q  = is_in ? inb_q : onb_q;
    assign o_hit = (32'(s_reg) < 32'(n_live)) && (ocnt_q != '0);
    assign i_hit = reverse_enable_reg && (32'(t_reg) < 32'(n_live)) && (icnt_q != '0);

    elcsr_ram #(.DEPTH(MAX_EDGES), .WIDTH(FW), .AW(EAW)) u_src (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(s_reg),
        .raddr(st_raddr), .rdata(src_q)
    );
    elcsr_ram #(.DEPTH(MAX_EDGES), .WIDTH(FW), .AW(EAW)) u_tgt (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(t_reg),
        .raddr(st_raddr), .rdata(tgt_q)
    );
    elcsr_ram #(.DEPTH(MAX_NODES), .WIDTH(ECW), .AW(NW)) u_ocnt (
        .clk(clk), .we(ocnt_we), .waddr(ocnt_waddr), .wdata(ocnt_wdata),
        .raddr(ocnt_raddr), .rdata(ocnt_q)
    );
    elcsr_ram #(.DEPTH(MAX_NODES), .WIDTH(ECW), .AW(NW)) u_icnt (
        .clk(clk), .we(icnt_we), .waddr(icnt_waddr), .wdata(icnt_wdata),
        .raddr(icnt_raddr), .rdata(icnt_q)
    );
    elcsr_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(ECW), .AW(OAW)) u_ooff (
        .clk(clk), .we(ooff_we), .waddr(off_waddr), .wdata(ooff_wdata),
        .raddr(ooff_raddr), .rdata(ooff_q)
    );
    elcsr_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(ECW), .AW(OAW)) u_ioff (
        .clk(clk), .we(ioff_we), .waddr(off_waddr), .wdata(ioff_wdata),
        .raddr(ioff_raddr), .rdata(ioff_q)
    );
    elcsr_ram #(.DEPTH(MAX_EDGES), .WIDTH(FW), .AW(EAW)) u_onb (
        .clk(clk), .we(onb_we), .waddr(onb_waddr), .wdata(onb_wdata),
        .raddr(nb_raddr), .rdata(onb_q)
    );
    elcsr_ram #(.DEPTH(MAX_EDGES), .WIDTH(FW), .AW(EAW)) u_inb (
        .clk(clk), .we(inb_we), .waddr(inb_waddr), .wdata(inb_wdata),
        .raddr(nb_raddr), .rdata(inb_q)
    );

    // memory addressing
    always_comb
    begin
        st_we      = (state_reg == S_ADD_WR);
        st_waddr   = EAW'(count_reg);
        st_raddr   = EAW'(e_reg);

        ocnt_raddr = NW'(i_reg);
        icnt_raddr = NW'(i_reg);
        if (state_reg == S_ADD_RD || state_reg == S_ADD_WR || state_reg == S_SC_WR)
        begin
            ocnt_raddr = NW'(s_reg);
            icnt_raddr = NW'(t_reg);
        end
        else if (state_reg == S_SC_ADR)
        begin
            // edge just fetched from the store
            ocnt_raddr = NW'(src_q);
            icnt_raddr = NW'(tgt_q);
        end
        ocnt_we    = 1'b0;
        icnt_we    = 1'b0;
        ocnt_waddr = NW'(s_reg);
        icnt_waddr = NW'(t_reg);
        ocnt_wdata = ocnt_q + ECW'(1);
        icnt_wdata = icnt_q + ECW'(1);
        case (state_reg)
            S_ADD_WR:
            begin
                ocnt_we = 1'b1;
                icnt_we = reverse_enable_reg;
            end
            S_SC_WR:
            begin
                ocnt_we    = o_hit;
                icnt_we    = i_hit;
                ocnt_wdata = ocnt_q - ECW'(1);
                icnt_wdata = icnt_q - ECW'(1);
            end
            S_CLR, S_INIT_CLR:
            begin
                ocnt_we    = 1'b1;
                icnt_we    = 1'b1;
                ocnt_waddr = NW'(i_reg);
                icnt_waddr = NW'(i_reg);
                ocnt_wdata = '0;
                icnt_wdata = '0;
            end
            default:
            begin
            end
        endcase

        ooff_we    = 1'b0;
        ioff_we    = 1'b0;
        off_waddr  = OAW'(i_reg + NCW'(1));
        ooff_wdata = oacc_next;
        ioff_wdata = iacc_next;
        if (state_reg == S_PFX_RD && i_reg == '0)
        begin
            ooff_we    = 1'b1;
            ioff_we    = 1'b1;
            off_waddr  = '0;
            ooff_wdata = '0;
            ioff_wdata = '0;
        end
        else if (state_reg == S_PFX_WR)
        begin
            ooff_we = 1'b1;
            ioff_we = 1'b1;
        end

        ooff_raddr = OAW'(s_reg);
        ioff_raddr = OAW'(t_reg);
        if (state_reg == S_RD_OFF)
        begin
            ooff_raddr = OAW'(idx_reg);
            ioff_raddr = OAW'(idx_reg);
        end
        else if (state_reg == S_RD_TOT)
        begin
            ooff_raddr = OAW'(n_live);
            ioff_raddr = OAW'(n_live);
        end
        else if (state_reg == S_SC_ADR)
        begin
            ooff_raddr = OAW'(src_q);
            ioff_raddr = OAW'(tgt_q);
        end

        nb_raddr  = EAW'(idx_reg);
        onb_we    = (state_reg == S_SC_WR) && o_hit;
        inb_we    = (state_reg == S_SC_WR) && i_hit;
        onb_waddr = EAW'(ooff_q + ocnt_q - ECW'(1));
        inb_waddr = EAW'(ioff_q + icnt_q - ECW'(1));
        onb_wdata = t_reg;
        inb_wdata = s_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        rev_ready_next = rev_ready_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        e_next         = e_reg;
        oacc_next      = oacc_reg;
        iacc_next      = iacc_reg;
        op_next        = op_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        idx_next       = idx_reg;
        done_next      = 1'b0;
        value_next     = value_reg;
        status_next    = status_reg;

        case (state_reg)
            S_INIT_CLR:
            begin
                i_next = i_reg + NCW'(1);
                if (i_reg == NCW'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = opcode;
                    s_next      = source_node;
                    t_next      = target_node;
                    idx_next    = read_index;
                    value_next  = '0;
                    status_next = elcsr_pkg::ST_OK;
                    i_next      = '0;
                    e_next      = '0;
                    oacc_next   = '0;
                    iacc_next   = '0;
                    case (opcode)
                        elcsr_pkg::OP_ADD:
                        begin
                            if (ready_reg)
                            begin
                                ready_next     = 1'b0;
                                rev_ready_next = 1'b0;
                                count_next     = '0;
                            end
                            if (32'(source_node) >= 32'(n_live)
                                || 32'(target_node) >= 32'(n_live))
                            begin
                                status_next = elcsr_pkg::ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (source_node == target_node)
                            begin
                                status_next = elcsr_pkg::ST_SELF;
                                done_next   = 1'b1;
                            end
                            else if (!ready_reg && count_reg == ECW'(MAX_EDGES))
                            begin
                                status_next = elcsr_pkg::ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ADD_RD;
                            end
                        end
                        elcsr_pkg::OP_BUILD:
                        begin
                            if (ready_reg)
                            begin
                                value_next = VW'(count_reg);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_PFX_RD;
                            end
                        end
                        elcsr_pkg::OP_OUT_OFF, elcsr_pkg::OP_IN_OFF,
                        elcsr_pkg::OP_OUT_NB, elcsr_pkg::OP_IN_NB:
                        begin
                            if (!ready_reg || (!rev_ready_reg
                                && (opcode == elcsr_pkg::OP_IN_OFF
                                    || opcode == elcsr_pkg::OP_IN_NB)))
                            begin
                                status_next = elcsr_pkg::ST_NOTBUILT;
                                done_next   = 1'b1;
                            end
                            else if (opcode == elcsr_pkg::OP_OUT_NB
                                     || opcode == elcsr_pkg::OP_IN_NB)
                            begin
                                state_next = S_RD_TOT;
                            end
                            else if (32'(read_index) > 32'(n_live))
                            begin
                                status_next = elcsr_pkg::ST_INDEX;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD_OFF;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                count_next = count_reg + ECW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_PFX_RD:
            begin
                if (n_live == '0)
                begin
                    state_next = (count_reg == '0) ? S_CLR : S_SC_RD;
                end
                else
                begin
                    state_next = S_PFX_WR;
                end
            end
            S_PFX_WR:
            begin
                oacc_next = oacc_reg + ocnt_q;
                iacc_next = reverse_enable_reg ? (iacc_reg + icnt_q) : iacc_reg;
                i_next    = i_reg + NCW'(1);
                if (i_reg + NCW'(1) == n_live)
                begin
                    i_next     = '0;
                    state_next = (count_reg == '0) ? S_CLR : S_SC_RD;
                end
                else
                begin
                    state_next = S_PFX_RD;
                end
            end
            S_SC_RD:
            begin
                state_next = S_SC_ADR;
            end
            S_SC_ADR:
            begin
                s_next     = src_q;
                t_next     = tgt_q;
                state_next = S_SC_WR;
            end
            S_SC_WR:
            begin
                e_next = e_reg + ECW'(1);
                if (e_reg + ECW'(1) == count_reg)
                begin
                    i_next     = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_SC_RD;
                end
            end
            S_CLR:
            begin
                i_next = i_reg + NCW'(1);
                if (i_reg == NCW'(MAX_NODES - 1))
                begin
                    ready_next     = 1'b1;
                    rev_ready_next = reverse_enable_reg;
                    value_next     = VW'(count_reg);
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD_OFF:
            begin
                state_next = S_RD_NB;
            end
            S_RD_TOT:
            begin
                state_next = S_RD_CHK;
            end
            S_RD_CHK:
            begin
                if (32'(idx_reg) >= 32'(off_sel_q) || 32'(idx_reg) >= 32'(MAX_EDGES))
                begin
                    status_next = elcsr_pkg::ST_INDEX;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_RD_NB;
                end
            end
            S_RD_NB:
            begin
                if (op_reg == elcsr_pkg::OP_OUT_OFF || op_reg == elcsr_pkg::OP_IN_OFF)
                begin
                    value_next = VW'(off_sel_q);
                end
                else
                begin
                    value_next = VW'(nb_sel_q);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_INIT_CLR;
            node_count_reg     <= elcsr_pkg::NODE_COUNT_RST;
            reverse_enable_reg <= 1'b1;
            ready_reg          <= 1'b0;
            rev_ready_reg      <= 1'b0;
            count_reg          <= '0;
            i_reg              <= '0;
            e_reg              <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            rev_ready_reg <= rev_ready_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            e_reg         <= e_next;
            done_reg      <= done_next;
            if (write_enable)
            begin
                case (write_index)
                    elcsr_pkg::CFG_NODE_COUNT: node_count_reg     <= write_data;
                    elcsr_pkg::CFG_REVERSE:    reverse_enable_reg <= write_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oacc_reg   <= oacc_next;
        iacc_reg   <= iacc_next;
        op_reg     <= op_next;
        s_reg      <= s_next;
        t_reg      <= t_next;
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

FILE: design/elcsr_ram.sv
// ----------------------------------------------------------------------------
// elcsr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module elcsr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 13,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
